### hdl/button_debounce_press_timer_unit_assert.svh
// Assertion macros for the button debounce press timer unit.
`ifndef BUTTON_DEBOUNCE_PRESS_TIMER_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdpt assertion failed");

// Next-cycle implication, checked outside reset.
`define BDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdpt assertion failed");

`endif

### hdl/bdpt_pkg.sv
// Package with payload types and codes for the button debounce press timer unit.
`default_nettype none

package bdpt_pkg;

  localparam logic [1:0] EvNone     = 2'd0;
  localparam logic [1:0] EvPressed  = 2'd1;
  localparam logic [1:0] EvReleased = 2'd2;

  localparam logic [1:0] RegPressedLevel      = 2'd0;
  localparam logic [1:0] RegActiveThreshold   = 2'd1;
  localparam logic [1:0] RegInactiveThreshold = 2'd2;

  localparam logic       CmdSample = 1'b0;

  localparam logic [3:0] ThresholdReset = 4'd5;
  localparam logic [3:0] RunMax         = 4'd15;
  localparam logic [7:0] HoldMax        = 8'd255;

  typedef struct packed {
    logic command;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [7:0] press_duration;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [3:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### hdl/bdpt_core.sv
// Debounce state, press timer, event latch and configuration registers.
`default_nettype none

module bdpt_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bdpt_pkg::cfg_wr_t  cfg_i,
  input  wire logic               accept_i,
  input  wire bdpt_pkg::in_item_t item_i,
  output bdpt_pkg::out_item_t     result_o
);

  localparam logic [1:0] ChkNone     = 2'd0;
  localparam logic [1:0] ChkEdge     = 2'd1;
  localparam logic [1:0] ChkActive   = 2'd2;
  localparam logic [1:0] ChkInactive = 2'd3;

  logic       pressed_level_q, pressed_level_d;
  logic [3:0] act_thr_q, act_thr_d;
  logic [3:0] inact_thr_q, inact_thr_d;
  logic       is_pressed_q, is_pressed_d;
  logic       watched_q, watched_d;
  logic       stable_q, stable_d;
  logic       last_q, last_d;
  logic [3:0] act_run_q, act_run_d;
  logic [3:0] inact_run_q, inact_run_d;
  logic [7:0] hold_q, hold_d;
  logic [1:0] pending_q, pending_d;
  logic [1:0] chk;

  always_comb begin
    pressed_level_d = pressed_level_q;
    act_thr_d       = act_thr_q;
    inact_thr_d     = inact_thr_q;
    is_pressed_d    = is_pressed_q;
    watched_d       = watched_q;
    stable_d        = stable_q;
    last_d          = last_q;
    act_run_d       = act_run_q;
    inact_run_d     = inact_run_q;
    hold_d          = hold_q;
    pending_d       = pending_q;
    chk             = ChkNone;
    result_o        = '0;

    if (accept_i) begin
      if (item_i.command == bdpt_pkg::CmdSample) begin
        if (stable_q) begin
          if (item_i.pin_level == watched_q && last_q != watched_q) begin
            chk         = ChkEdge;
            act_run_d   = '0;
            inact_run_d = '0;
            stable_d    = 1'b0;
          end
        end else if (item_i.pin_level == watched_q) begin
          inact_run_d = '0;
          act_run_d   = (act_run_q != bdpt_pkg::RunMax) ? act_run_q + 4'd1 : act_run_q;
          if (act_run_d >= act_thr_q) begin
            stable_d = 1'b1;
            chk      = ChkActive;
          end
        end else begin
          act_run_d   = '0;
          inact_run_d = (inact_run_q != bdpt_pkg::RunMax) ? inact_run_q + 4'd1 : inact_run_q;
          if (inact_run_d >= inact_thr_q) begin
            stable_d = 1'b1;
            chk      = ChkInactive;
          end
        end
        last_d = item_i.pin_level;

        if (!is_pressed_q) begin
          if (chk == ChkEdge) begin
            pending_d    = bdpt_pkg::EvPressed;
            hold_d       = '0;
            is_pressed_d = 1'b1;
          end
        end else begin
          case (chk)
            ChkNone: begin
              if (hold_q != bdpt_pkg::HoldMax) begin
                hold_d = hold_q + 8'd1;
              end
            end
            ChkActive: begin
              watched_d = ~watched_q;
            end
            ChkInactive: begin
              watched_d    = pressed_level_q;
              is_pressed_d = 1'b0;
            end
            default: begin
              pending_d    = bdpt_pkg::EvReleased;
              watched_d    = pressed_level_q;
              is_pressed_d = 1'b0;
            end
          endcase
        end
      end else begin
        result_o.event_code = pending_q;
        if (pending_q == bdpt_pkg::EvReleased) begin
          result_o.press_duration = hold_q;
        end
        pending_d = bdpt_pkg::EvNone;
      end
    end

    if (cfg_i.valid) begin
      case (cfg_i.index)
        bdpt_pkg::RegPressedLevel: begin
          pressed_level_d = cfg_i.data[0];
          watched_d       = cfg_i.data[0];
        end
        bdpt_pkg::RegActiveThreshold: begin
          act_thr_d = cfg_i.data;
        end
        bdpt_pkg::RegInactiveThreshold: begin
          inact_thr_d = cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_level_q <= 1'b0;
      act_thr_q       <= bdpt_pkg::ThresholdReset;
      inact_thr_q     <= bdpt_pkg::ThresholdReset;
      is_pressed_q    <= 1'b0;
      watched_q       <= 1'b0;
      stable_q        <= 1'b1;
      last_q          <= 1'b1;
      act_run_q       <= '0;
      inact_run_q     <= '0;
      hold_q          <= '0;
      pending_q       <= bdpt_pkg::EvNone;
    end else begin
      pressed_level_q <= pressed_level_d;
      act_thr_q       <= act_thr_d;
      inact_thr_q     <= inact_thr_d;
      is_pressed_q    <= is_pressed_d;
      watched_q       <= watched_d;
      stable_q        <= stable_d;
      last_q          <= last_d;
      act_run_q       <= act_run_d;
      inact_run_q     <= inact_run_d;
      hold_q          <= hold_d;
      pending_q       <= pending_d;
    end
  end

endmodule

`default_nettype wire

### hdl/bdpt_out_reg.sv
// Result register that decouples the output channel from the input channel.
`default_nettype none

module bdpt_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bdpt_pkg::out_item_t result_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bdpt_pkg::out_item_t      out_data_o
);

  logic                valid_q;
  bdpt_pkg::out_item_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

### hdl/button_debounce_press_timer_unit.sv
// Top level of the debounced push-button with press-duration timer.
//
// Channel  Direction  Signals                                   Payload
// in       input      in_valid_i, in_ready_o, in_data_i         command, pin_level
// out      output     out_valid_o, out_ready_i, out_data_o      event_code, press_duration
// cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i,    register index and value
//                     cfg_data_i
//
// Every accepted item gives one result in the cycle after it is accepted, held in the single result register.
// A new item is taken in every cycle while the result register is empty or being read.
// A stalled output holds its result and blocks further input transfers until it is taken.
// Reset loads the default thresholds and the released state; configuration is always ready.
`default_nettype none
`include "button_debounce_press_timer_unit_assert.svh"

module button_debounce_press_timer_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bdpt_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bdpt_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [3:0]          cfg_data_i
);

  bdpt_pkg::cfg_wr_t   cfg;
  bdpt_pkg::out_item_t result;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;
  assign accept      = in_valid_i && in_ready_o;

  bdpt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_data_i),
    .result_o (result)
  );

  bdpt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `BDPT_ASSERT_NEXT(a_result_follows, accept, out_valid_o)
  `BDPT_ASSERT_IMPL(a_code_legal, out_valid_o, out_data_o.event_code != 2'd3)
  `BDPT_ASSERT_IMPL(a_duration_only_released,
    out_valid_o && out_data_o.event_code != bdpt_pkg::EvReleased,
    out_data_o.press_duration == 8'd0)
  `BDPT_ASSERT_IMPL(a_sample_result_empty,
    out_valid_o && $past(accept) && $past(in_data_i.command) == bdpt_pkg::CmdSample,
    out_data_o.event_code == bdpt_pkg::EvNone)

endmodule

`default_nettype wire
